// ===== hw/rtl/hbr_pkg.sv =====
// ----------------------------------------------------------------------------
// hbr_pkg: shared definitions of the byte range parser
// Widths, character codes, prefix text and the job record of the parse queue.
// ----------------------------------------------------------------------------
package hbr_pkg;

  localparam int HBR_SIZE_BITS   = 48;
  localparam int HBR_ACC_BITS    = 64;
  localparam int HBR_ACC_EXT     = HBR_ACC_BITS + 4;
  localparam int HBR_QUEUE_DEPTH = 2;
  localparam int HBR_PREFIX_LEN  = 6;

  localparam logic [7:0] CHAR_DASH  = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // parse outcome flags handed from front to back
  typedef struct packed {
    logic syntax_error;
    logic prefix_done;
    logic dash_seen;
    logic left_present;
    logic right_present;
  } hbr_flags_t;

  typedef struct packed {
    hbr_flags_t              flags;
    logic [HBR_ACC_BITS-1:0] left_value;
    logic [HBR_ACC_BITS-1:0] right_value;
  } hbr_job_t;

  // expected character of the unit text "bytes=" at a given position
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h79;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h73;
      3'd5:    c = 8'h3d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/hbr_in_if.sv =====
// ----------------------------------------------------------------------------
// hbr_in_if: header byte channel
// Valid/ready channel carrying one header byte, the resource size and a last flag.
// ----------------------------------------------------------------------------
interface hbr_in_if #(
  parameter int SizeBits = 48
);
  logic                valid;
  logic                ready;
  logic [7:0]          header_byte;
  logic [SizeBits-1:0] resource_size;
  logic                final_byte;

  modport source (output valid, header_byte, resource_size, final_byte, input ready);
  modport sink   (input valid, header_byte, resource_size, final_byte, output ready);
endinterface

// ===== hw/rtl/hbr_out_if.sv =====
// ----------------------------------------------------------------------------
// hbr_out_if: range result channel
// Valid/ready channel carrying the satisfiable flag and the inclusive offsets.
// ----------------------------------------------------------------------------
interface hbr_out_if #(
  parameter int SizeBits = 48
);
  logic                valid;
  logic                ready;
  logic                satisfiable;
  logic [SizeBits-1:0] first_offset;
  logic [SizeBits-1:0] final_offset;

  modport source (output valid, satisfiable, first_offset, final_offset, input ready);
  modport sink   (input valid, satisfiable, first_offset, final_offset, output ready);
endinterface

// ===== hw/rtl/hbr_front.sv =====
// ----------------------------------------------------------------------------
// hbr_front: header byte parser
// Matches the unit prefix, tracks the dash and accumulates both numbers.
// ----------------------------------------------------------------------------
module hbr_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                byte_valid_i,
  input  logic [7:0]                          byte_i,
  input  logic                                final_i,
  input  logic                                queue_full_i,
  output logic                                byte_ready_o,
  output logic                                push_o,
  output hbr_pkg::hbr_job_t                   job_o
);
  import hbr_pkg::*;

  logic [2:0]              prefix_pos_q, prefix_pos_d;
  logic                    dash_q, dash_d;
  logic                    err_q, err_d;
  logic [HBR_ACC_BITS-1:0] left_q, left_d;
  logic [HBR_ACC_BITS-1:0] right_q, right_d;
  logic                    left_pres_q, left_pres_d;
  logic                    right_pres_q, right_pres_d;

  logic                    accept;
  logic                    is_digit;
  logic [3:0]              digit;
  logic [HBR_ACC_BITS-1:0] acc;
  logic [HBR_ACC_EXT-1:0]  acc_ext;
  logic [HBR_ACC_EXT-1:0]  acc_next;
  logic                    acc_ovf;

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  assign is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign digit    = 4'(byte_i - CHAR_ZERO);
  assign acc      = dash_q ? right_q : left_q;
  assign acc_ext  = HBR_ACC_EXT'(acc);
  // times ten as shift-add, plus the digit
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + HBR_ACC_EXT'(digit);
  assign acc_ovf  = |acc_next[HBR_ACC_EXT-1:HBR_ACC_BITS];

  always_comb begin
    prefix_pos_d = prefix_pos_q;
    dash_d       = dash_q;
    err_d        = err_q;
    left_d       = left_q;
    right_d      = right_q;
    left_pres_d  = left_pres_q;
    right_pres_d = right_pres_q;
    if (!err_q) begin
      if (prefix_pos_q < 3'(HBR_PREFIX_LEN)) begin
        if (byte_i != prefix_char(prefix_pos_q)) begin
          err_d = 1'b1;
        end else begin
          prefix_pos_d = prefix_pos_q + 3'd1;
        end
      end else if (byte_i == CHAR_DASH) begin
        if (dash_q) begin
          err_d = 1'b1;
        end else begin
          dash_d = 1'b1;
        end
      end else if (is_digit) begin
        if (acc_ovf) begin
          err_d = 1'b1;
        end
        if (!dash_q) begin
          if (!acc_ovf) begin
            left_d = acc_next[HBR_ACC_BITS-1:0];
          end
          left_pres_d = 1'b1;
        end else begin
          if (!acc_ovf) begin
            right_d = acc_next[HBR_ACC_BITS-1:0];
          end
          right_pres_d = 1'b1;
        end
      end else begin
        err_d = 1'b1;
      end
    end
  end

  assign push_o                    = accept && final_i;
  assign job_o.flags.syntax_error  = err_d;
  assign job_o.flags.prefix_done   = (prefix_pos_d == 3'(HBR_PREFIX_LEN));
  assign job_o.flags.dash_seen     = dash_d;
  assign job_o.flags.left_present  = left_pres_d;
  assign job_o.flags.right_present = right_pres_d;
  assign job_o.left_value          = left_d;
  assign job_o.right_value         = right_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_pos_q <= '0;
      dash_q       <= 1'b0;
      err_q        <= 1'b0;
      left_q       <= '0;
      right_q      <= '0;
      left_pres_q  <= 1'b0;
      right_pres_q <= 1'b0;
    end else if (accept) begin
      if (final_i) begin
        // header done, start over for the next one
        prefix_pos_q <= '0;
        dash_q       <= 1'b0;
        err_q        <= 1'b0;
        left_q       <= '0;
        right_q      <= '0;
        left_pres_q  <= 1'b0;
        right_pres_q <= 1'b0;
      end else begin
        prefix_pos_q <= prefix_pos_d;
        dash_q       <= dash_d;
        err_q        <= err_d;
        left_q       <= left_d;
        right_q      <= right_d;
        left_pres_q  <= left_pres_d;
        right_pres_q <= right_pres_d;
      end
    end
  end

endmodule

// ===== hw/rtl/hbr_queue.sv =====
// ----------------------------------------------------------------------------
// hbr_queue: parse job queue
// Short register queue between the parser and the range evaluator.
// ----------------------------------------------------------------------------
module hbr_queue #(
  parameter int SizeBits = hbr_pkg::HBR_SIZE_BITS,
  parameter int Depth    = hbr_pkg::HBR_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hbr_pkg::hbr_job_t   job_i,
  input  logic [SizeBits-1:0] size_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output hbr_pkg::hbr_job_t   job_o,
  output logic [SizeBits-1:0] size_o
);
  import hbr_pkg::*;

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  hbr_job_t            job_mem [Depth];
  logic [SizeBits-1:0] size_mem [Depth];
  logic [PtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]  count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntBits'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = job_mem[rd_ptr_q];
  assign size_o  = size_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      job_mem[wr_ptr_q]  <= job_i;
      size_mem[wr_ptr_q] <= size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntBits'(do_push) - CntBits'(do_pop);
    end
  end

endmodule

// ===== hw/rtl/hbr_back.sv =====
// ----------------------------------------------------------------------------
// hbr_back: range evaluator
// Checks a parsed range against the resource size and registers the result.
// ----------------------------------------------------------------------------
module hbr_back #(
  parameter int SizeBits = hbr_pkg::HBR_SIZE_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  hbr_pkg::hbr_job_t   job_i,
  input  logic [SizeBits-1:0] size_i,
  output logic                pop_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic                satisfiable_o,
  output logic [SizeBits-1:0] first_offset_o,
  output logic [SizeBits-1:0] final_offset_o
);
  import hbr_pkg::*;

  logic                    valid_q;
  logic                    sat_q, sat_d;
  logic [SizeBits-1:0]     first_q, first_d;
  logic [SizeBits-1:0]     last_q, last_d;
  logic [HBR_ACC_BITS-1:0] size_w, size_m1, end_w, first_w, last_w;
  logic                    base_ok, ok;

  assign pop_o = job_valid_i && (!valid_q || res_ready_i);

  assign size_w  = HBR_ACC_BITS'(size_i);
  assign size_m1 = size_w - HBR_ACC_BITS'(1);
  assign end_w   = job_i.flags.right_present ? job_i.right_value : size_m1;
  assign base_ok = !job_i.flags.syntax_error && job_i.flags.prefix_done &&
                   job_i.flags.dash_seen &&
                   (job_i.flags.left_present || job_i.flags.right_present) &&
                   (size_w != '0);

  always_comb begin
    if (!job_i.flags.left_present) begin
      // suffix form: last n bytes
      ok      = base_ok && (job_i.right_value != '0);
      first_w = (job_i.right_value >= size_w) ? '0 : size_w - job_i.right_value;
      last_w  = size_m1;
    end else begin
      ok      = base_ok && (job_i.left_value < size_w) && !(job_i.left_value > end_w);
      first_w = job_i.left_value;
      last_w  = (end_w < size_m1) ? end_w : size_m1;
    end
    sat_d   = ok;
    first_d = ok ? first_w[SizeBits-1:0] : '0;
    last_d  = ok ? last_w[SizeBits-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sat_q   <= sat_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  assign res_valid_o    = valid_q;
  assign satisfiable_o  = sat_q;
  assign first_offset_o = first_q;
  assign final_offset_o = last_q;

endmodule

// ===== hw/rtl/http_byte_range_parser.sv =====
// ----------------------------------------------------------------------------
// http_byte_range_parser: single byte range parser for an http range header
// Parses "bytes=" first-last, first- or -suffix and reports the inclusive range.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        moves per transfer
//  in_i     in   header_byte, resource_size, final_byte         one header byte
//  out_o    out  satisfiable, first_offset, final_offset        one range result
//
//  one header byte is taken per cycle while the queue is not full; the job of
//  the final byte is written into the queue, then into the evaluator register,
//  whose valid is the output valid
//  each digit passes the 68-bit times-ten shift-add of the digit accumulator
//  reset clears the parser state, the queue pointers and the output valid
//  a stalled output fills the two-entry queue; in_i.ready drops only when full
// ----------------------------------------------------------------------------
module http_byte_range_parser #(
  parameter int SIZE_BITS = hbr_pkg::HBR_SIZE_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  hbr_in_if.sink    in_i,
  hbr_out_if.source out_o
);
  import hbr_pkg::*;

  // front to queue
  logic                 push;
  logic                 queue_full;
  hbr_job_t             push_job;

  // queue to back
  logic                 job_valid;
  logic                 pop;
  hbr_job_t             head_job;
  logic [SIZE_BITS-1:0] head_size;

  // parser: prefix match, dash tracking, number accumulation
  hbr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_i.valid),
    .byte_i       (in_i.header_byte),
    .final_i      (in_i.final_byte),
    .queue_full_i (queue_full),
    .byte_ready_o (in_i.ready),
    .push_o       (push),
    .job_o        (push_job)
  );

  // short queue of finished headers so the parser waits on the output only when it is full
  hbr_queue #(
    .SizeBits (SIZE_BITS),
    .Depth    (HBR_QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .size_i  (in_i.resource_size),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (head_job),
    .size_o  (head_size)
  );

  // range check against the size, result held in the output register
  hbr_back #(
    .SizeBits (SIZE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (head_job),
    .size_i         (head_size),
    .pop_o          (pop),
    .res_valid_o    (out_o.valid),
    .res_ready_i    (out_o.ready),
    .satisfiable_o  (out_o.satisfiable),
    .first_offset_o (out_o.first_offset),
    .final_offset_o (out_o.final_offset)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: byte range parser stream check
// Streams Range header values byte by byte into the parser and holds its own
// parse state to predict every range result. The results are compared in
// order, under several patterns of sender gaps, receiver stalls and one long
// output hold.
// ----------------------------------------------------------------------------
module testbench;

  import hbr_pkg::*;

  localparam int SIZE_BITS       = HBR_SIZE_BITS;
  localparam int UNIT_LEN        = HBR_PREFIX_LEN;
  localparam logic [47:0] RANGE_UNIT = "bytes=";
  localparam logic [7:0]  CHAR_COMMA = 8'h2c;
  localparam logic [63:0] ACC_MAX    = 64'hffff_ffff_ffff_ffff;
  localparam int TAIL_CYCLES     = 6;      // extra wait after the last expected result is taken
  localparam int HOLD_CYCLES     = 400;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT  = 4000;   // cycles without any transfer
  localparam int PRINT_CAP       = 100;

  typedef struct packed {
    logic                 satisfiable;
    logic [SIZE_BITS-1:0] first_offset;
    logic [SIZE_BITS-1:0] final_offset;
  } range_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hbr_in_if  #(.SizeBits(SIZE_BITS)) in_if ();
  hbr_out_if #(.SizeBits(SIZE_BITS)) out_if ();

  http_byte_range_parser #(
    .SIZE_BITS(SIZE_BITS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  // predicted parse state of the header in flight
  int          unit_matched;
  logic        dash_taken;
  logic        parse_failed;
  logic [63:0] start_acc;
  logic        start_has;
  logic [63:0] stop_acc;
  logic        stop_has;

  range_result_t expected_ranges[$];
  range_result_t got_range;
  logic [7:0]    hdr_bytes[$];

  int  mismatches = 0;
  int  src_idle_pct = 0;
  int  sink_stall_pct = 0;
  int  quiet_cycles = 0;
  logic hold_rx = 1'b0;
  event hold_go;

  // --------------------------------------------------------------------------
  // range prediction
  // --------------------------------------------------------------------------
  function automatic void clear_parser();
    unit_matched = 0;
    dash_taken   = 1'b0;
    parse_failed = 1'b0;
    start_acc    = '0;
    start_has    = 1'b0;
    stop_acc     = '0;
    stop_has     = 1'b0;
  endfunction

  // times ten plus digit; refuses when the 64-bit accumulator would wrap
  function automatic logic shift_in_digit(inout logic [63:0] acc, input logic [3:0] d);
    if (acc > (ACC_MAX - 64'(d)) / 64'd10) return 1'b0;
    acc = acc * 64'd10 + 64'(d);
    return 1'b1;
  endfunction

  function automatic void parse_header_byte(logic [7:0] b);
    logic [7:0] want;
    if (parse_failed) return;           // everything after an error is dropped
    if (unit_matched < UNIT_LEN) begin
      want = RANGE_UNIT[8*(UNIT_LEN-1-unit_matched) +: 8];
      if (b != want) parse_failed = 1'b1;
      else unit_matched++;
      return;
    end
    if (b == CHAR_DASH) begin
      if (dash_taken) parse_failed = 1'b1;
      else dash_taken = 1'b1;
    end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      if (!dash_taken) begin
        if (!shift_in_digit(start_acc, b[3:0])) parse_failed = 1'b1;
        start_has = 1'b1;
      end else begin
        if (!shift_in_digit(stop_acc, b[3:0])) parse_failed = 1'b1;
        stop_has = 1'b1;
      end
    end else begin
      parse_failed = 1'b1;
    end
  endfunction

  function automatic range_result_t range_verdict(logic [SIZE_BITS-1:0] size);
    range_result_t r;
    logic [63:0] sz;
    logic [63:0] stop;
    logic [63:0] lo;
    logic [63:0] hi;
    r  = '0;
    sz = 64'(size);
    if (parse_failed || unit_matched < UNIT_LEN || !dash_taken) return r;
    if (!start_has && !stop_has) return r;
    if (sz == 64'd0) return r;
    hi = sz - 64'd1;
    if (!start_has) begin
      // suffix form: last n bytes, whole resource when n covers it
      if (stop_acc == 64'd0) return r;
      lo = (stop_acc >= sz) ? 64'd0 : sz - stop_acc;
    end else begin
      stop = stop_has ? stop_acc : hi;   // open end runs to the last byte
      if (start_acc >= sz || start_acc > stop) return r;
      lo = start_acc;
      if (stop < hi) hi = stop;
    end
    r.satisfiable  = 1'b1;
    r.first_offset = lo[SIZE_BITS-1:0];
    r.final_offset = hi[SIZE_BITS-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  // one byte transfer; starts and ends at a falling edge
  task automatic send_item(logic [7:0] b, logic [SIZE_BITS-1:0] size, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.header_byte   <= b;
    in_if.resource_size <= size;
    in_if.final_byte    <= last;
    do @(posedge clk_i); while (!in_if.ready);
    parse_header_byte(b);
    if (last) begin
      expected_ranges.insert(expected_ranges.size(), range_verdict(size));
      clear_parser();
    end
    @(negedge clk_i);
  endtask

  task automatic send_header(logic [SIZE_BITS-1:0] size);
    for (int i = 0; i < hdr_bytes.size(); i++)
      send_item(hdr_bytes[i], size, i == hdr_bytes.size() - 1);
    hdr_bytes.delete();
  endtask

  function automatic void add_byte(logic [7:0] b);
    hdr_bytes.insert(hdr_bytes.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  task automatic send_text(string s, logic [SIZE_BITS-1:0] size);
    add_text(s);
    send_header(size);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // random header content
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand_wide();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_size();
    logic [63:0] w;
    int sel;
    sel = $urandom_range(99);
    w   = rand_wide();
    if (sel < 5) w = '0;
    else if (sel < 40) w = 64'($urandom_range(20, 1));
    else if (sel < 65) w = 64'($urandom_range(1000, 1));
    else if (sel < 90) w = w;
    else w = ACC_MAX;
    return w[SIZE_BITS-1:0];
  endfunction

  // number text near the interesting points of the given size
  function automatic string number_text(logic [63:0] size);
    logic [63:0] v;
    string s;
    int sel;
    sel = $urandom_range(99);
    v   = rand_wide();
    case (sel % 10)
      0: v = 64'd0;
      1: v = size - 64'd1;
      2: v = size;
      3: v = size + 64'd1;
      4: v = v % (size + 64'd1);
      5: v = 64'($urandom_range(30));
      6: v = v % (size + 64'd1);
      7: v = {16'd0, v[47:0]};
      8: v = ACC_MAX - 64'($urandom_range(3));
      default: v = v;
    endcase
    s = $sformatf("%0d", v);
    if (sel < 4) s = {"18446744073709551616", s};    // certain overflow
    else if (sel < 12) s = {"0", s};                  // leading zero
    return s;
  endfunction

  task automatic build_range(logic [SIZE_BITS-1:0] size);
    int form;
    form = $urandom_range(9);
    add_text("bytes=");
    if (form < 4) begin
      add_text(number_text(64'(size)));
      add_byte(CHAR_DASH);
      add_text(number_text(64'(size)));
    end else if (form < 6) begin
      add_text(number_text(64'(size)));
      add_byte(CHAR_DASH);
    end else if (form < 9) begin
      add_byte(CHAR_DASH);
      add_text(number_text(64'(size)));
    end else if ($urandom_range(1)) begin
      add_byte(CHAR_DASH);
    end else begin
      add_text(number_text(64'(size)));
    end
  endtask

  function automatic void spoil_header();
    int pos;
    pos = $urandom_range(hdr_bytes.size() - 1);
    case ($urandom_range(4))
      0: hdr_bytes[pos] = 8'($urandom_range(255));
      1: hdr_bytes.insert(pos, CHAR_COMMA);
      2: hdr_bytes.insert(pos, CHAR_DASH);
      3: hdr_bytes.insert(pos, 8'($urandom_range(255)));
      default: while (hdr_bytes.size() > pos + 1) void'(hdr_bytes.pop_back());
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_text("x", 48'd100);                         // bad first byte
    send_text("bytes", 48'd100);                     // prefix cut short
    send_text("bytes=5", 48'd100);                   // no dash
    send_text("bytes=-", 48'd100);                   // both numbers empty
    send_text("bytes=0-9", 48'd0);                   // empty resource
    send_text("bytes=-0", 48'd100);                  // zero suffix
    send_text("bytes=-500", 48'd100);                // suffix covers all
    send_text("bytes=-10", 48'd100);                 // plain suffix
    send_text("bytes=10-", 48'd100);                 // open end
    send_text("bytes=100-", 48'd100);                // start at size
    send_text("bytes=9-5", 48'd100);                 // start above end
    send_text("bytes=0-999", 48'd100);               // end clamped
    send_text("bytes=0-0", 48'd1);
    send_text("bytes=0-18446744073709551615", 48'hffff_ffff_ffff);
    send_text("bytes=18446744073709551616-", 48'hffff_ffff_ffff);  // overflow
    send_text("bytes=1-2,3-4", 48'd100);             // comma
    send_text("bytes=1--2", 48'd100);                // second dash
    add_text("bytes=x");                             // junk after an error
    add_byte(8'h00);
    add_byte(8'hff);
    send_header(48'd100);
    wait_drain();
  endtask

  // mostly well-formed headers, some spoiled, some pure noise
  task automatic test_random_traffic(int budget, int src_pct, int sink_pct);
    logic [SIZE_BITS-1:0] size;
    int counted;
    int sel;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    counted        = 0;
    while (counted < budget) begin
      size = pick_size();
      sel  = $urandom_range(99);
      if (sel < 12) begin
        repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255)));
      end else begin
        build_range(size);
        if (sel < 30) spoil_header();
        counted += hdr_bytes.size();
      end
      send_header(size);
    end
    wait_drain();
  endtask

  // receiver holds off while the sender keeps offering: the queue fills up
  task automatic test_output_hold();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    -> hold_go;
    for (int i = 0; i < 10; i++)
      send_text($sformatf("bytes=%0d-%0d", i, i + 3), 48'd50);
    wait_drain();
  endtask

  // --------------------------------------------------------------------------
  // receiver side and checking
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= !hold_rx && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // long hold-off, counted here in cycles
  initial begin
    forever begin
      @(hold_go);
      hold_rx = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_rx = 1'b0;
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_ranges.size() == 0) begin
        report_mismatch("range result with no header pending");
      end else begin
        got_range = expected_ranges.pop_front();
        if (out_if.satisfiable !== got_range.satisfiable)
          report_mismatch($sformatf("satisfiable %b, want %b",
                                    out_if.satisfiable, got_range.satisfiable));
        if (out_if.first_offset !== got_range.first_offset)
          report_mismatch($sformatf("first_offset %0d, want %0d",
                                    out_if.first_offset, got_range.first_offset));
        if (out_if.final_offset !== got_range.final_offset)
          report_mismatch($sformatf("final_offset %0d, want %0d",
                                    out_if.final_offset, got_range.final_offset));
      end
    end
  end

  // ends a run that stops moving
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("** http_byte_range_parser: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid         = 1'b0;
    in_if.header_byte   = '0;
    in_if.resource_size = '0;
    in_if.final_byte    = 1'b0;
    clear_parser();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_traffic(250, 0, 0);
    test_random_traffic(250, 53, 0);
    test_random_traffic(250, 0, 53);
    test_random_traffic(250, 30, 30);
    test_output_hold();

    if (mismatches == 0 && expected_ranges.size() == 0) begin
      $display("** http_byte_range_parser: PASSED **");
    end else begin
      $display("** http_byte_range_parser: FAILED **");
    end
    $finish;
  end

endmodule

// ===== http_byte_range_parser.f =====
hw/rtl/hbr_pkg.sv
hw/rtl/hbr_in_if.sv
hw/rtl/hbr_out_if.sv
hw/rtl/hbr_front.sv
hw/rtl/hbr_queue.sv
hw/rtl/hbr_back.sv
hw/rtl/http_byte_range_parser.sv
dv/testbench.sv
